@@ hdl/detection_ground_truth_matcher_core_assert.svh @@
// Assertion macros for the detection to ground-truth matcher
`ifndef DETECTION_GROUND_TRUTH_MATCHER_CORE_ASSERT_SVH
`define DETECTION_GROUND_TRUTH_MATCHER_CORE_ASSERT_SVH
`ifndef SYNTH
`define DGTM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DGTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DGTM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DGTM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/dgtm_pkg.sv @@
// Package: types, constants and opcodes of the detection to ground-truth matcher
`default_nettype none
package dgtm_pkg;
	localparam int MAX_TRUTHS_DEF = 32;
	localparam int COORD_BITS_DEF = 12;
	localparam logic [16:0] IOU_ONE = 17'd65536;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_DETECT = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic [COORD_BITS_DEF-1:0] box_x;
		logic [COORD_BITS_DEF-1:0] box_y;
		logic [COORD_BITS_DEF-1:0] box_w;
		logic [COORD_BITS_DEF-1:0] box_h;
		logic [7:0]                object_class;
		logic [15:0]               score;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pred_index;
		logic [16:0] match_iou;
		logic        gt_found;
		logic [4:0]  truth_idx;
		logic [7:0]  pred_class;
		logic [15:0] pred_score;
		logic        primary;
		logic        demoted_valid;
		logic [15:0] demoted_index;
	} out_item_t;

	// divider request / response
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [47:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/dgtm_div.sv @@
// Restoring divider: 17-bit quotient of num/den, one bit per cycle
`default_nettype none
module dgtm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dgtm_pkg::div_req_t req,
	output dgtm_pkg::div_rsp_t     rsp
);
	import dgtm_pkg::*;

	localparam int QB = 17;

	logic [63:0] rem_q;
	logic [47:0] den_q;
	logic [QB-1:0] quo_q;
	logic [4:0] cnt_q;
	logic busy_q, done_q;
	logic [64:0] trial;

	// quotient is known below 2^17 since num < den * 2^17 is guaranteed by caller
	assign trial = {1'b0, rem_q} - ({17'd0, den_q} << (cnt_q - 5'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

@@ hdl/detection_ground_truth_matcher_core.sv @@
// Top level of the detection to ground-truth matcher
//
//  channel  dir  handshake        payload
//  in       in   in_valid/ready   dgtm_pkg::in_item_t
//  out      out  out_valid/ready  dgtm_pkg::out_item_t
//
// A start clears the per-truth records by a sweep over all MAX_TRUTHS entries; reset runs
// the same sweep. A detection visits the N stored truths in turn; each truth whose box
// overlaps the detection box waits on the one-bit-per-cycle divider (17 steps). The truth
// table and records are memories with a registered read, whose data lands in the cycle
// after the address. A detection stalls before its record update while the previous
// result is still waiting on out.
`default_nettype none
`include "detection_ground_truth_matcher_core_assert.svh"
module detection_ground_truth_matcher_core #(
	parameter int MAX_TRUTHS = dgtm_pkg::MAX_TRUTHS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dgtm_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output dgtm_pkg::out_item_t      out_data
);
	import dgtm_pkg::*;

	localparam int AW = (MAX_TRUTHS > 1) ? $clog2(MAX_TRUTHS) : 1;
	localparam int CW = $clog2(MAX_TRUTHS + 1);
	localparam int CB = COORD_BITS_DEF;
	localparam int TW = 4 * CB + 8;
	localparam int RW = 1 + 17 + 1 + 16 + 17;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CLEAR = 9'b000000010,
		ST_RD    = 9'b000000100,
		ST_CALC  = 9'b000001000,
		ST_MUL   = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_REC   = 9'b001000000,
		ST_UPD   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q;

	// truth table memory
	logic [TW-1:0] truth_mem [MAX_TRUTHS];
	logic [TW-1:0] truth_rd_q;
	// per-truth record memory: seen, highest, holder_valid, number, holder_iou
	logic [RW-1:0] rec_mem [MAX_TRUTHS];
	logic [RW-1:0] rec_rd_q;

	logic [CW-1:0] count_q;
	logic [15:0] det_q;
	logic [AW-1:0] idx_q, clr_q;
	logic [AW-1:0] best_g_q;
	logic [16:0] best_q;
	logic found_q;
	in_item_t cur_q;
	logic [15:0] number_q;

	logic [CB-1:0] cx, cy, cw, ch, tx, ty, tw, th;
	logic [7:0] tcls, best_cls_q;
	logic signed [CB+2:0] ow_s1, oh_s1;
	logic [2*CB-1:0] ta_s1, ca_s1;
	logic [2*CB+3:0] inter_q;
	logic [2*CB+3:0] uni_q;
	logic [16:0] iou_val;
	logic iou_pos;
	logic div_go_q;
	div_req_t dreq;
	div_rsp_t drsp;
	out_item_t res_q;
	logic out_valid_q;

	logic rec_we;
	logic [AW-1:0] rec_wa;
	logic [RW-1:0] rec_wd;

	function automatic logic signed [CB+2:0] span(input logic [CB-1:0] c1, s1, c2, s2);
		logic signed [CB+2:0] l1, l2, r1, r2, lft, rgt;
		l1 = $signed({2'b0, c1, 1'b0}) - $signed({3'b0, s1});
		l2 = $signed({2'b0, c2, 1'b0}) - $signed({3'b0, s2});
		r1 = $signed({2'b0, c1, 1'b0}) + $signed({3'b0, s1});
		r2 = $signed({2'b0, c2, 1'b0}) + $signed({3'b0, s2});
		lft = (l1 > l2) ? l1 : l2;
		rgt = (r1 < r2) ? r1 : r2;
		return rgt - lft;
	endfunction

	assign cx = cur_q.box_x[CB-1:0];
	assign cy = cur_q.box_y[CB-1:0];
	assign cw = cur_q.box_w[CB-1:0];
	assign ch = cur_q.box_h[CB-1:0];
	assign {tx, ty, tw, th, tcls} = truth_rd_q;

	assign in_ready = (state_q == ST_IDLE);

	// truth memory write and registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && in_ready && in_data.operation == OP_LOAD
		    && count_q < CW'(MAX_TRUTHS))
			truth_mem[count_q[AW-1:0]] <= {in_data.box_x[CB-1:0], in_data.box_y[CB-1:0],
				in_data.box_w[CB-1:0], in_data.box_h[CB-1:0], in_data.object_class};
		truth_rd_q <= truth_mem[idx_q];
	end

	// record memory
	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[rec_wa] <= rec_wd;
		rec_rd_q <= rec_mem[best_g_q];
	end

	// IoU of the divider result; divider starts on the first ST_DIV cycle
	assign iou_val = (uni_q <= inter_q) ? IOU_ONE : drsp.quo;
	assign dreq.num = 64'({inter_q, 16'd0});
	assign dreq.den = 48'(uni_q - inter_q);
	assign dreq.start = div_go_q && iou_pos && (uni_q > inter_q);

	logic iou_pos_q;
	assign iou_pos = iou_pos_q;

	dgtm_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// record update logic
	logic r_seen, r_hv;
	logic [16:0] r_hi, r_hiou;
	logic [15:0] r_num;
	logic cls_eq, prim, dem;
	assign {r_seen, r_hi, r_hv, r_num, r_hiou} = rec_rd_q;
	assign cls_eq = (cur_q.object_class == best_cls_q);
	assign dem = cls_eq && r_hv && (r_hiou < best_q);
	assign prim = cls_eq && (!r_seen || r_hi < best_q);

	always_comb begin
		rec_we = 1'b0;
		rec_wa = best_g_q;
		rec_wd = rec_rd_q;
		if (state_q == ST_CLEAR) begin
			rec_we = 1'b1;
			rec_wa = clr_q;
			rec_wd = '0;
		end else if (state_q == ST_UPD && found_q) begin
			rec_we = 1'b1;
			rec_wd = {1'b1, (!r_seen || r_hi < best_q) ? best_q : r_hi,
				prim ? 1'b1 : (dem ? 1'b0 : r_hv),
				prim ? number_q : r_num,
				prim ? best_q : r_hiou};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= '0;
			det_q       <= '0;
			clr_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			div_go_q    <= 1'b0;
		end else begin
			div_go_q <= (state_q == ST_MUL);
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cur_q <= in_data;
						idx_q <= '0;
						case (in_data.operation)
							OP_START: begin
								count_q <= '0;
								det_q   <= '0;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							OP_LOAD: begin
								if (count_q < CW'(MAX_TRUTHS))
									count_q <= count_q + CW'(1);
							end
							OP_DETECT: begin
								number_q <= det_q;
								det_q    <= det_q + 16'd1;
								best_q   <= '0;
								best_g_q <= '0;
								found_q  <= 1'b0;
								state_q  <= (count_q == '0) ? ST_REC : ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_TRUTHS - 1))
						state_q <= ST_IDLE;
				end
				ST_RD: state_q <= ST_CALC; // truth read data lands
				ST_CALC: begin
					ow_s1 <= span(tx, tw, cx, cw);
					oh_s1 <= span(ty, th, cy, ch);
					ta_s1 <= tw * th;
					ca_s1 <= cw * ch;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// intersection and union land in inter_q / uni_q
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!iou_pos || uni_q <= inter_q || drsp.done) begin
						if (iou_pos && iou_val > best_q) begin
							best_q     <= iou_val;
							best_g_q   <= idx_q;
							best_cls_q <= tcls;
							found_q    <= 1'b1;
						end
						if (CW'(idx_q) + CW'(1) >= count_q) begin
							state_q <= ST_REC;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				// record read data lands; hold until the result register is free
				ST_REC: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					res_q.pred_index    <= number_q;
					res_q.match_iou     <= best_q;
					res_q.gt_found      <= found_q;
					res_q.truth_idx     <= found_q ? 5'(best_g_q) : 5'd0;
					res_q.pred_class    <= cur_q.object_class;
					res_q.pred_score    <= cur_q.score;
					res_q.primary       <= found_q && prim;
					res_q.demoted_valid <= found_q && dem;
					res_q.demoted_index <= (found_q && dem) ? r_num : 16'd0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// intersection and union, registered after the products
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			iou_pos_q <= (ow_s1 > 0) && (oh_s1 > 0);
			inter_q   <= (2*CB+4)'(ow_s1[CB+1:0]) * (2*CB+4)'(oh_s1[CB+1:0]);
			uni_q     <= (2*CB+4)'({ta_s1, 2'b0}) + (2*CB+4)'({ca_s1, 2'b0});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	`DGTM_ASSERT_IMP(a_in_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`DGTM_ASSERT_IMP(a_prim_found, clk, arst_n, out_valid, !out_data.primary || out_data.gt_found)
	`DGTM_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(MAX_TRUTHS))
	`DGTM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the detection to ground-truth matcher: directed and random images
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import dgtm_pkg::*;

	localparam int NTRUTH = 32;
	localparam int LIMIT_CYCLES = 4000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	detection_ground_truth_matcher_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// clock, 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// matcher state mirror
	logic [11:0] gt_x [NTRUTH];
	logic [11:0] gt_y [NTRUTH];
	logic [11:0] gt_w [NTRUTH];
	logic [11:0] gt_h [NTRUTH];
	logic [7:0] gt_cls [NTRUTH];
	int unsigned gt_count;
	bit seen [NTRUTH];
	logic [16:0] top_iou [NTRUTH];
	bit hold_v [NTRUTH];
	logic [15:0] hold_num [NTRUTH];
	logic [16:0] hold_iou [NTRUTH];
	logic [15:0] det_count;

	out_item_t match_q[$];
	int errors;
	longint cycles;
	bit busy_hold;

	// doubled 1-D overlap
	function automatic longint overlap2(input logic [11:0] c1, s1, c2, s2);
		longint l1, l2, r1, r2, lo, hi;
		l1 = 2 * longint'(c1) - longint'(s1);
		l2 = 2 * longint'(c2) - longint'(s2);
		r1 = 2 * longint'(c1) + longint'(s1);
		r2 = 2 * longint'(c2) + longint'(s2);
		lo = (l1 > l2) ? l1 : l2;
		hi = (r1 < r2) ? r1 : r2;
		return hi - lo;
	endfunction

	function automatic logic [16:0] iou_q16(input int g, input in_item_t d);
		longint ow, oh;
		longint unsigned inter, uni;
		ow = overlap2(gt_x[g], gt_w[g], d.box_x, d.box_w);
		oh = overlap2(gt_y[g], gt_h[g], d.box_y, d.box_h);
		if (ow <= 0 || oh <= 0)
			return '0;
		inter = longint'(ow) * longint'(oh);
		uni = 4 * longint'(gt_w[g]) * gt_h[g] + 4 * longint'(d.box_w) * d.box_h;
		if (uni <= inter)
			return IOU_ONE;
		uni = uni - inter;
		return 17'((inter << 16) / uni);
	endfunction

	task automatic clear_image();
		gt_count = 0;
		det_count = '0;
		for (int g = 0; g < NTRUTH; g++) begin
			seen[g] = 0;
			top_iou[g] = '0;
			hold_v[g] = 0;
			hold_num[g] = '0;
			hold_iou[g] = '0;
		end
	endtask

	// update mirror for one accepted item, queue the match result if any
	task automatic predict_match(input in_item_t d);
		out_item_t r;
		logic [16:0] best, v;
		int bg;
		bit hit, prim;
		best = '0;
		bg = 0;
		hit = 0;
		case (op_t'(d.operation))
			OP_START: clear_image();
			OP_LOAD: begin
				if (gt_count < NTRUTH) begin
					gt_x[gt_count] = d.box_x;
					gt_y[gt_count] = d.box_y;
					gt_w[gt_count] = d.box_w;
					gt_h[gt_count] = d.box_h;
					gt_cls[gt_count] = d.object_class;
					gt_count++;
				end
			end
			OP_DETECT: begin
				r = '0;
				r.pred_index = det_count;
				det_count = det_count + 16'd1;
				for (int g = 0; g < gt_count; g++) begin
					v = iou_q16(g, d);
					if (v > best) begin
						best = v;
						bg = g;
						hit = 1;
					end
				end
				if (hit) begin
					if (d.object_class == gt_cls[bg]) begin
						if (hold_v[bg] && hold_iou[bg] < best) begin
							r.demoted_valid = 1'b1;
							r.demoted_index = hold_num[bg];
							hold_v[bg] = 0;
						end
						prim = !seen[bg] || top_iou[bg] < best;
						if (prim) begin
							hold_v[bg] = 1;
							hold_num[bg] = r.pred_index;
							hold_iou[bg] = best;
						end
						r.primary = prim;
					end
					if (!seen[bg] || top_iou[bg] < best)
						top_iou[bg] = best;
					seen[bg] = 1;
				end
				r.match_iou = best;
				r.gt_found = hit;
				r.truth_idx = hit ? 5'(bg) : '0;
				r.pred_class = d.object_class;
				r.pred_score = d.score;
				match_q = {match_q, r};
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// send one item with a random gap before it
	task automatic send_item(input in_item_t d);
		repeat ($urandom_range(0, 9)) @(negedge clk);
		in_data = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_match(d);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			out_item_t e;
			if (match_q.size() == 0) begin
				report("unexpected result", 64'(out_data.pred_index), '0);
			end else begin
				e = match_q.pop_front();
				if (out_data.pred_index !== e.pred_index)
					report("pred_index", 64'(out_data.pred_index), 64'(e.pred_index));
				if (out_data.match_iou !== e.match_iou)
					report("match_iou", 64'(out_data.match_iou), 64'(e.match_iou));
				if (out_data.gt_found !== e.gt_found)
					report("gt_found", 64'(out_data.gt_found), 64'(e.gt_found));
				if (out_data.truth_idx !== e.truth_idx)
					report("truth_idx", 64'(out_data.truth_idx), 64'(e.truth_idx));
				if (out_data.pred_class !== e.pred_class)
					report("pred_class", 64'(out_data.pred_class), 64'(e.pred_class));
				if (out_data.pred_score !== e.pred_score)
					report("pred_score", 64'(out_data.pred_score), 64'(e.pred_score));
				if (out_data.primary !== e.primary)
					report("primary", 64'(out_data.primary), 64'(e.primary));
				if (out_data.demoted_valid !== e.demoted_valid)
					report("demoted_valid", 64'(out_data.demoted_valid),
						64'(e.demoted_valid));
				if (out_data.demoted_index !== e.demoted_index)
					report("demoted_index", 64'(out_data.demoted_index),
						64'(e.demoted_index));
			end
		end
	end

	// receiver stalls: random wait per result, sometimes none
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (busy_hold) begin
				out_ready = 1'b1;
			end else if (out_valid) begin
				n = $urandom_range(0, 9);
				if (n != 0) begin
					out_ready = 1'b0;
					repeat (n) @(negedge clk);
				end
				out_ready = 1'b1;
				@(posedge clk);
				while (!out_valid) @(posedge clk);
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic in_item_t mk(input op_t op, input logic [11:0] x, y, w, h,
		input logic [7:0] c, input logic [15:0] s);
		in_item_t d;
		d.operation = op;
		d.box_x = x;
		d.box_y = y;
		d.box_w = w;
		d.box_h = h;
		d.object_class = c;
		d.score = s;
		return d;
	endfunction

	function automatic in_item_t rnd_item(input op_t op);
		return mk(op, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
			8'($urandom), 16'($urandom));
	endfunction

	// box near a given truth, so overlaps are common
	function automatic in_item_t near_det(input int g, input logic [7:0] c);
		in_item_t d;
		d = rnd_item(OP_DETECT);
		d.box_x = gt_x[g] + 12'($urandom_range(0, 40)) - 12'd20;
		d.box_y = gt_y[g] + 12'($urandom_range(0, 40)) - 12'd20;
		d.box_w = gt_w[g] + 12'($urandom_range(0, 40)) - 12'd20;
		d.box_h = gt_h[g] + 12'($urandom_range(0, 40)) - 12'd20;
		d.object_class = c;
		return d;
	endfunction

	task automatic wait_drain();
		while (match_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
	endtask

	// extremes, zero union, ties, class mismatch, demotions, unused code
	task automatic test_directed();
		send_item(mk(OP_START, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_DETECT, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 8'hff, 16'hffff));
		send_item(mk(OP_LOAD, 100, 100, 0, 0, 3, 0));
		send_item(mk(OP_LOAD, 2000, 2000, 400, 400, 5, 0));
		send_item(mk(OP_LOAD, 2000, 2000, 400, 400, 5, 0));
		send_item(mk(OP_LOAD, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 8'hff, 0));
		send_item(mk(OP_DETECT, 100, 100, 0, 0, 3, 16'h1234));
		send_item(mk(OP_DETECT, 2000, 2000, 300, 300, 5, 1));
		send_item(mk(OP_DETECT, 2000, 2000, 300, 300, 5, 2));
		send_item(mk(OP_DETECT, 2000, 2000, 400, 400, 6, 3));
		send_item(mk(OP_DETECT, 2000, 2000, 350, 350, 5, 4));
		send_item(mk(OP_DETECT, 2000, 2000, 400, 400, 5, 5));
		send_item(mk(OP_NONE, 12'hfff, 0, 12'hfff, 0, 8'hff, 16'hffff));
		send_item(mk(OP_DETECT, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 8'hff, 16'hffff));
		send_item(mk(OP_DETECT, 0, 0, 12'hfff, 12'hfff, 0, 0));
		send_item(mk(OP_DETECT, 0, 0, 0, 0, 0, 0));
		wait_drain();
	endtask

	// fill past capacity, then detect
	task automatic test_full_table();
		send_item(mk(OP_START, 0, 0, 0, 0, 0, 0));
		for (int i = 0; i < NTRUTH + 3; i++)
			send_item(rnd_item(OP_LOAD));
		for (int i = 0; i < 40; i++)
			send_item($urandom_range(0, 1) ? near_det($urandom_range(0, NTRUTH - 1),
				gt_cls[$urandom_range(0, NTRUTH - 1)]) : rnd_item(OP_DETECT));
		wait_drain();
	endtask

	// random images, mostly small tables and near detections
	task automatic test_random_images();
		int sent;
		int nt;
		sent = 0;
		while (sent < 1350) begin
			send_item(mk(OP_START, 12'($urandom), 0, 0, 0, 0, 0));
			nt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NTRUTH + 2)
				: $urandom_range(0, 5);
			for (int i = 0; i < nt; i++) begin
				in_item_t d;
				d = rnd_item(OP_LOAD);
				d.object_class = 8'($urandom_range(0, 3));
				if ($urandom_range(0, 3) == 0) d.object_class = 8'($urandom);
				send_item(d);
			end
			sent += nt + 1;
			for (int i = 0; i < $urandom_range(1, 12); i++) begin
				int sel;
				sel = $urandom_range(0, 19);
				if (gt_count != 0 && sel < 15)
					send_item(near_det($urandom_range(0, gt_count - 1),
						8'($urandom_range(0, 3))));
				else if (sel < 18)
					send_item(rnd_item(OP_DETECT));
				else
					send_item(rnd_item(OP_NONE));
				sent++;
			end
			// receiver fully open for some images
			busy_hold = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 30) == 0) wait_drain();
		end
		busy_hold = 0;
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		busy_hold = 0;
		in_valid = 1'b0;
		in_data = '0;
		clear_image();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_random_images();
		wait_drain();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

@@ detection_ground_truth_matcher_core.f @@
+incdir+hdl
hdl/dgtm_pkg.sv
hdl/dgtm_div.sv
hdl/detection_ground_truth_matcher_core.sv
tb/sv/tb_top.sv
